// ===== sv/rfae_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfae_pkg: shared types and constants for the register file alu executor
// Holds the instruction codes, datapath widths, stream packing offsets and
// the control bundle that the sequencer hands to the shared arithmetic unit.
// ----------------------------------------------------------------------------
package rfae_pkg;

    // datapath
    localparam int DATA_W        = 32;
    localparam int CNT_W         = $clog2(DATA_W);
    localparam int REG_COUNT_DEF = 4;

    // instruction field widths
    localparam int MODE_W  = 4;
    localparam int REGF_W  = 2;

    // input beat layout, lowest bit first
    localparam int MODE_LSB   = 0;
    localparam int DEST_LSB   = MODE_LSB + MODE_W;
    localparam int SRCA_LSB   = DEST_LSB + REGF_W;
    localparam int SRCB_LSB   = SRCA_LSB + REGF_W;
    localparam int THREE_LSB  = SRCB_LSB + REGF_W;
    localparam int IMM_LSB    = THREE_LSB + 1;
    localparam int S_FIELDS_W = IMM_LSB + DATA_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // instruction codes
    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_LOAD = 4'd0;
    localparam t_mode MODE_OUT  = 4'd1;
    localparam t_mode MODE_MOVE = 4'd2;
    localparam t_mode MODE_XCHG = 4'd3;
    localparam t_mode MODE_ADD  = 4'd4;
    localparam t_mode MODE_SUB  = 4'd5;
    localparam t_mode MODE_MUL  = 4'd6;
    localparam t_mode MODE_MOD  = 4'd7;
    localparam t_mode MODE_AND  = 4'd8;
    localparam t_mode MODE_OR   = 4'd9;
    localparam t_mode MODE_XOR  = 4'd10;

    // request from the sequencer to the arithmetic unit
    typedef struct packed {
        logic  start;
        t_mode op;
    } t_alu_ctl;

endpackage

// ===== sv/rfae_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfae_ram: generic ram, one write port and two registered read ports
// Write data lands at the clock edge; each read port returns the entry
// addressed in the previous cycle.
// ----------------------------------------------------------------------------
module rfae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr0,
    input  logic [ADDR_W-1:0] i_rd_addr1,
    output logic [WIDTH-1:0]  o_rd_data0,
    output logic [WIDTH-1:0]  o_rd_data1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        o_rd_data0 <= r_mem[i_rd_addr0];
        o_rd_data1 <= r_mem[i_rd_addr1];
    end

endmodule

// ===== sv/rfae_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfae_alu: shared iterative arithmetic unit
// One 33-bit adder serves add, subtract, magnitude and sign fix-up, a
// shift-add multiply of 32 steps and a restoring remainder of 32 steps.
// ----------------------------------------------------------------------------
module rfae_alu
    import rfae_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_ctl          i_ctl,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic              o_done,
    output logic [DATA_W-1:0] o_result
);

    typedef enum logic [4:0] {
        AS_IDLE = 5'b00001,
        AS_NEGA = 5'b00010,
        AS_NEGB = 5'b00100,
        AS_RUN  = 5'b01000,
        AS_FIX  = 5'b10000
    } t_alu_state;

    t_alu_state        r_state;
    t_mode             r_op;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W-1:0] r_md;
    logic [DATA_W-1:0] r_mr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic              r_done;
    logic [DATA_W-1:0] r_res;

    logic [DATA_W:0]   add_l;
    logic [DATA_W:0]   add_r;
    logic              add_cin;
    logic [DATA_W+1:0] add_sum;
    logic [DATA_W:0]   rem_sh;
    logic              last_step;

    assign rem_sh    = {r_acc, r_md[DATA_W-1]};
    assign last_step = (r_cnt == CNT_W'(DATA_W - 1));

    // operand selection for the shared adder
    always_comb begin
        add_l   = '0;
        add_r   = '0;
        add_cin = 1'b0;
        unique case (r_state)
            AS_IDLE: begin
                add_l = {1'b0, i_a};
                if (i_ctl.op == MODE_SUB) begin
                    add_r   = ~{1'b0, i_b};
                    add_cin = 1'b1;
                end else begin
                    add_r = {1'b0, i_b};
                end
            end
            AS_NEGA: begin
                add_r   = ~{1'b0, r_md};
                add_cin = 1'b1;
            end
            AS_NEGB: begin
                add_r   = ~{1'b0, r_mr};
                add_cin = 1'b1;
            end
            AS_RUN: begin
                if (r_op == MODE_MUL) begin
                    add_l = {1'b0, r_acc};
                    add_r = r_mr[0] ? {1'b0, r_md} : '0;
                end else begin
                    // trial subtract of the divisor magnitude
                    add_l   = rem_sh;
                    add_r   = ~{1'b0, r_mr};
                    add_cin = 1'b1;
                end
            end
            AS_FIX: begin
                add_r   = ~{1'b0, r_acc};
                add_cin = 1'b1;
            end
            default: begin
                add_l = '0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_l} + {1'b0, add_r} + (DATA_W+2)'(add_cin);

    // sequencer of the unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= AS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                AS_IDLE: begin
                    if (i_ctl.start) begin
                        r_op <= i_ctl.op;
                        unique case (i_ctl.op)
                            MODE_ADD, MODE_SUB: begin
                                r_res  <= add_sum[DATA_W-1:0];
                                r_done <= 1'b1;
                            end
                            MODE_AND: begin
                                r_res  <= i_a & i_b;
                                r_done <= 1'b1;
                            end
                            MODE_OR: begin
                                r_res  <= i_a | i_b;
                                r_done <= 1'b1;
                            end
                            MODE_XOR: begin
                                r_res  <= i_a ^ i_b;
                                r_done <= 1'b1;
                            end
                            MODE_MUL: begin
                                r_acc   <= '0;
                                r_md    <= i_a;
                                r_mr    <= i_b;
                                r_cnt   <= '0;
                                r_state <= AS_RUN;
                            end
                            MODE_MOD: begin
                                r_acc   <= '0;
                                r_md    <= i_a;
                                r_mr    <= i_b;
                                r_cnt   <= '0;
                                r_neg   <= i_a[DATA_W-1];
                                r_state <= AS_NEGA;
                            end
                            default: begin
                                r_res  <= '0;
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                AS_NEGA: begin
                    if (r_md[DATA_W-1]) begin
                        r_md <= add_sum[DATA_W-1:0];
                    end
                    r_state <= AS_NEGB;
                end
                AS_NEGB: begin
                    if (r_mr[DATA_W-1]) begin
                        r_mr <= add_sum[DATA_W-1:0];
                    end
                    r_state <= AS_RUN;
                end
                AS_RUN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    r_md  <= {r_md[DATA_W-2:0], 1'b0};
                    if (r_op == MODE_MUL) begin
                        r_acc <= add_sum[DATA_W-1:0];
                        r_mr  <= {1'b0, r_mr[DATA_W-1:1]};
                        if (last_step) begin
                            r_res   <= add_sum[DATA_W-1:0];
                            r_done  <= 1'b1;
                            r_state <= AS_IDLE;
                        end
                    end else begin
                        // keep the difference when no borrow
                        r_acc <= add_sum[DATA_W+1] ? add_sum[DATA_W-1:0]
                                                   : rem_sh[DATA_W-1:0];
                        if (last_step) begin
                            r_state <= AS_FIX;
                        end
                    end
                end
                AS_FIX: begin
                    // remainder takes the sign of the dividend
                    r_res   <= r_neg ? add_sum[DATA_W-1:0] : r_acc;
                    r_done  <= 1'b1;
                    r_state <= AS_IDLE;
                end
                default: begin
                    r_state <= AS_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == AS_IDLE)
        else $error("alu start while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("alu done longer than one cycle");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == AS_RUN && r_op == MODE_MOD) |-> r_acc < r_mr)
        else $error("partial remainder not below divisor");
`endif

endmodule

// ===== sv/register_file_alu_executor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register_file_alu_executor: decoded instruction executor on a register file
// Runs one instruction per input beat on REG_COUNT 32-bit registers.
// ----------------------------------------------------------------------------
// Each input beat is one decoded instruction; the block drops tready while it
// works on it. Exchange makes two writes through the single ram write port;
// multiply and modulo step one bit per cycle through the shared adder. Output
// and modulo by zero leave the result in an output register, so the next beat
// is taken while it waits; only a second result waits for the first to drain.
// A modulo by zero returns value 0 with tuser high and leaves the destination
// unchanged. Register indexes wrap modulo REG_COUNT. All registers read as zero
// after reset, tracked by one valid bit per entry.
module register_file_alu_executor
    import rfae_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // mode[3:0], dest_reg[5:4], src_a[7:6], src_b[9:8], three_operand[10],
    // immediate[42:11], zero pad[47:43]
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // value[31:0]
    output logic [DATA_W-1:0]    o_m_tdata,
    // status[0]
    output logic                 o_m_tuser,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready
);

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SWAP = 5'b00100,
        S_EXEC = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // register index wraps modulo the file size
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [REGF_W-1:0] f);
        logic [4:0] w;
        w = 5'(f);
        if (w >= 5'(REG_COUNT)) begin
            w = w - 5'(REG_COUNT);
        end
        return w[IDX_W-1:0];
    endfunction

    t_state            r_state, n_state;
    t_mode             r_mode;
    logic [IDX_W-1:0]  r_d;
    logic [IDX_W-1:0]  r_ra;
    logic [DATA_W-1:0] r_imm;
    logic [DATA_W-1:0] r_hold, n_hold;
    logic              r_err, n_err;
    logic              r_vld [REG_COUNT];
    logic              r_rv0, r_rv1;
    logic              r_o_valid;
    logic [DATA_W-1:0] r_o_data;
    logic              r_o_err;

    t_mode             in_mode;
    logic [IDX_W-1:0]  in_d, in_ra, in_rb;
    logic              in_three;
    logic              in_arith;
    logic              s_accept;
    logic [IDX_W-1:0]  rd_addr0, rd_addr1;
    logic [DATA_W-1:0] rd_data0, rd_data1;
    logic [DATA_W-1:0] op_x, op_y;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              out_load;
    t_alu_ctl          alu_ctl;
    logic              alu_done;
    logic [DATA_W-1:0] alu_result;

    // input beat fields
    assign in_mode  = i_s_tdata[MODE_LSB +: MODE_W];
    assign in_d     = wrap_idx(i_s_tdata[DEST_LSB +: REGF_W]);
    assign in_ra    = wrap_idx(i_s_tdata[SRCA_LSB +: REGF_W]);
    assign in_rb    = wrap_idx(i_s_tdata[SRCB_LSB +: REGF_W]);
    assign in_three = i_s_tdata[THREE_LSB];
    assign in_arith = (in_mode >= MODE_ADD) && (in_mode <= MODE_XOR);

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    // operand addresses, issued in the accept cycle
    assign rd_addr0 = (in_arith && in_three) ? in_ra : in_d;
    assign rd_addr1 = (in_arith && in_three) ? in_rb : in_ra;

    rfae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_data),
        .i_rd_addr0 (rd_addr0),
        .i_rd_addr1 (rd_addr1),
        .o_rd_data0 (rd_data0),
        .o_rd_data1 (rd_data1)
    );

    // never written entries read as zero
    assign op_x = r_rv0 ? rd_data0 : '0;
    assign op_y = r_rv1 ? rd_data1 : '0;

    rfae_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_a      (op_x),
        .i_b      (op_y),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    assign out_load = (r_state == S_OUT) && (!r_o_valid || i_m_tready);

    // instruction sequencer
    always_comb begin
        n_state       = r_state;
        n_hold        = r_hold;
        n_err         = r_err;
        wr_en         = 1'b0;
        wr_addr       = r_d;
        wr_data       = op_y;
        alu_ctl.start = 1'b0;
        alu_ctl.op    = r_mode;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                unique case (r_mode)
                    MODE_LOAD: begin
                        wr_en   = 1'b1;
                        wr_data = r_imm;
                        n_state = S_IDLE;
                    end
                    MODE_OUT: begin
                        n_hold  = op_x;
                        n_err   = 1'b0;
                        n_state = S_OUT;
                    end
                    MODE_MOVE: begin
                        wr_en   = 1'b1;
                        n_state = S_IDLE;
                    end
                    MODE_XCHG: begin
                        wr_en   = 1'b1;
                        n_hold  = op_x;
                        n_state = S_SWAP;
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_AND, MODE_OR, MODE_XOR: begin
                        alu_ctl.start = 1'b1;
                        n_state       = S_EXEC;
                    end
                    MODE_MOD: begin
                        if (op_y == '0) begin
                            n_hold  = '0;
                            n_err   = 1'b1;
                            n_state = S_OUT;
                        end else begin
                            alu_ctl.start = 1'b1;
                            n_state       = S_EXEC;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SWAP: begin
                wr_en   = 1'b1;
                wr_addr = r_ra;
                wr_data = r_hold;
                n_state = S_IDLE;
            end
            S_EXEC: begin
                if (alu_done) begin
                    wr_en   = 1'b1;
                    wr_data = alu_result;
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // instruction fields and read valid, no reset needed
    always_ff @(posedge i_clk) begin
        r_rv0  <= r_vld[rd_addr0];
        r_rv1  <= r_vld[rd_addr1];
        r_hold <= n_hold;
        r_err  <= n_err;
        if (s_accept) begin
            r_mode <= in_mode;
            r_d    <= in_d;
            r_ra   <= in_ra;
            r_imm  <= i_s_tdata[IMM_LSB +: DATA_W];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_data <= r_hold;
            r_o_err  <= r_err;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_err;

`ifndef ASSERT_OFF
    a_done_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> r_state == S_EXEC)
        else $error("alu result outside execute state");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_state != S_IDLE)
        else $error("register write while idle");

    a_accept_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_state == S_READ)
        else $error("accepted beat not followed by operand read");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tdata == '0)
        else $error("error result with nonzero value");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the register file alu executor
// Sends decoded instructions on the input stream and keeps a shadow copy of
// the four registers that works out the value or error beat each instruction
// should return. Directed cases cover the field extremes, every instruction,
// modulo by zero and the most negative dividend, then long random streams
// run under changing sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import rfae_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              status;
    } t_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [DATA_W-1:0]    o_m_tdata;
    logic                 o_m_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;

    // shadow register file and results still to come back
    logic [DATA_W-1:0] reg_shadow [REG_COUNT_DEF];
    t_result           expected_results [$];

    int error_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int quiet_cycles = 0;

    register_file_alu_executor #(
        .REG_COUNT (REG_COUNT_DEF)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (stall_pct == 0) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // work out the effect of one accepted instruction on the shadow registers
    task automatic exec_instr(input t_mode op, input logic [REGF_W-1:0] d,
                              input logic [REGF_W-1:0] a, input logic [REGF_W-1:0] b,
                              input logic three, input logic [DATA_W-1:0] imm);
        int unsigned       di, ai, bi;
        logic [DATA_W-1:0] x, y, r, mag_x, mag_y;
        di = d % REG_COUNT_DEF;
        ai = a % REG_COUNT_DEF;
        bi = b % REG_COUNT_DEF;
        case (op)
            MODE_LOAD: begin
                reg_shadow[di] = imm;
            end
            MODE_OUT: begin
                expected_results.push_back('{value: reg_shadow[di], status: 1'b0});
            end
            MODE_MOVE: begin
                reg_shadow[di] = reg_shadow[ai];
            end
            MODE_XCHG: begin
                r = reg_shadow[di];
                reg_shadow[di] = reg_shadow[ai];
                reg_shadow[ai] = r;
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_MOD, MODE_AND, MODE_OR, MODE_XOR: begin
                x = three ? reg_shadow[ai] : reg_shadow[di];
                y = three ? reg_shadow[bi] : reg_shadow[ai];
                if (op == MODE_MOD && y == '0) begin
                    // divide by zero: error beat, destination kept
                    expected_results.push_back('{value: '0, status: 1'b1});
                end else begin
                    case (op)
                        MODE_ADD: r = x + y;
                        MODE_SUB: r = x - y;
                        MODE_MUL: r = x * y;
                        MODE_MOD: begin
                            // remainder carries the sign of the dividend
                            mag_x = x[DATA_W-1] ? -x : x;
                            mag_y = y[DATA_W-1] ? -y : y;
                            r = mag_x % mag_y;
                            if (x[DATA_W-1]) begin
                                r = -r;
                            end
                        end
                        MODE_AND: r = x & y;
                        MODE_OR:  r = x | y;
                        default:  r = x ^ y;
                    endcase
                    reg_shadow[di] = r;
                end
            end
            default: ;
        endcase
    endtask

    // drive one instruction beat and wait for it to be taken
    task automatic send_instr(input t_mode op, input logic [REGF_W-1:0] d,
                              input logic [REGF_W-1:0] a, input logic [REGF_W-1:0] b,
                              input logic three, input logic [DATA_W-1:0] imm);
        logic [S_TDATA_W-1:0] beat;
        beat = '0;
        beat[MODE_LSB +: MODE_W]  = op;
        beat[DEST_LSB +: REGF_W]  = d;
        beat[SRCA_LSB +: REGF_W]  = a;
        beat[SRCB_LSB +: REGF_W]  = b;
        beat[THREE_LSB]           = three;
        beat[IMM_LSB +: DATA_W]   = imm;
        @(negedge i_clk);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= beat;
        do @(posedge i_clk); while (!o_s_tready);
        exec_instr(op, d, a, b, three, imm);
    endtask

    // compare each returned beat with the oldest expectation
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{value: o_m_tdata, status: o_m_tuser};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual value %h status %b",
                         $time, got.value, got.status);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.value !== want.value) begin
                    $display("%0t: value mismatch, expected %h actual %h",
                             $time, want.value, got.value);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch, expected %b actual %b",
                             $time, want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // operand mix: full range, small values near zero, and the extremes
    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        case ($urandom_range(3))
            0: v = DATA_W'($urandom_range(16)) - DATA_W'(8);
            1: begin
                case ($urandom_range(4))
                    0: v = '0;
                    1: v = 32'h0000_0001;
                    2: v = 32'hffff_ffff;
                    3: v = 32'h8000_0000;
                    default: v = 32'h7fff_ffff;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_load_and_output();
        send_instr(MODE_LOAD, 2'd0, 2'd3, 2'd3, 1'b1, 32'h7fff_ffff);
        send_instr(MODE_LOAD, 2'd1, 2'd0, 2'd0, 1'b0, 32'h8000_0000);
        send_instr(MODE_LOAD, 2'd2, 2'd0, 2'd0, 1'b0, 32'hffff_ffff);
        send_instr(MODE_LOAD, 2'd3, 2'd0, 2'd0, 1'b0, 32'h0000_0000);
        send_instr(MODE_OUT,  2'd0, 2'd3, 2'd3, 1'b1, 32'hffff_ffff);
        send_instr(MODE_OUT,  2'd1, 2'd0, 2'd0, 1'b0, 32'h0000_0000);
    endtask

    task automatic test_modulo_corners();
        // divide by zero keeps r0
        send_instr(MODE_MOD,  2'd0, 2'd3, 2'd0, 1'b0, 32'h0);
        send_instr(MODE_OUT,  2'd0, 2'd0, 2'd0, 1'b0, 32'h0);
        // most negative by minus one gives zero
        send_instr(MODE_MOD,  2'd3, 2'd1, 2'd2, 1'b1, 32'h0);
        send_instr(MODE_OUT,  2'd3, 2'd0, 2'd0, 1'b0, 32'h0);
        // negative dividend, two operand form
        send_instr(MODE_LOAD, 2'd3, 2'd0, 2'd0, 1'b0, 32'hffff_fff9);
        send_instr(MODE_MOD,  2'd3, 2'd0, 2'd0, 1'b0, 32'h0);
        send_instr(MODE_OUT,  2'd3, 2'd0, 2'd0, 1'b0, 32'h0);
    endtask

    task automatic test_arith_logic();
        t_mode op;
        for (int m = MODE_ADD; m <= MODE_XOR; m++) begin
            op = t_mode'(m);
            send_instr(op, 2'd3, 2'd0, 2'd1, 1'b1, 32'h0);
            send_instr(MODE_OUT, 2'd3, 2'd0, 2'd0, 1'b0, 32'h0);
        end
        send_instr(MODE_ADD, 2'd0, 2'd0, 2'd1, 1'b0, 32'h0);
        send_instr(MODE_OUT, 2'd0, 2'd0, 2'd0, 1'b0, 32'h0);
    endtask

    task automatic test_moves_and_unknown();
        send_instr(MODE_MOVE, 2'd3, 2'd2, 2'd1, 1'b1, 32'h5555_aaaa);
        send_instr(MODE_XCHG, 2'd1, 2'd1, 2'd0, 1'b0, 32'h0);
        send_instr(MODE_XCHG, 2'd0, 2'd1, 2'd3, 1'b1, 32'h0);
        send_instr(t_mode'(4'd11), 2'd0, 2'd1, 2'd2, 1'b1, 32'h1234_5678);
        send_instr(t_mode'(4'd15), 2'd1, 2'd2, 2'd3, 1'b0, 32'hffff_ffff);
        send_instr(MODE_OUT,  2'd0, 2'd0, 2'd0, 1'b0, 32'h0);
        send_instr(MODE_OUT,  2'd1, 2'd0, 2'd0, 1'b0, 32'h0);
    endtask

    // random instruction stream under one setting of sender idling and receiver stalls
    task automatic test_random_stream(input int count, input int idle, input int stall);
        int    pick;
        t_mode op;
        idle_pct  = idle;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 18) begin
                op = MODE_LOAD;
            end else if (pick < 38) begin
                op = MODE_OUT;
            end else if (pick < 48) begin
                op = $urandom_range(1) ? MODE_MOVE : MODE_XCHG;
            end else if (pick < 95) begin
                op = t_mode'($urandom_range(MODE_XOR, MODE_ADD));
            end else begin
                op = t_mode'($urandom_range(15, 11));
            end
            send_instr(op, REGF_W'($urandom), REGF_W'($urandom), REGF_W'($urandom),
                       1'($urandom), (op == MODE_LOAD) ? pick_operand() : $urandom);
        end
    endtask

    // test sequence
    initial begin
        for (int i = 0; i < REG_COUNT_DEF; i++) begin
            reg_shadow[i] = '0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_load_and_output();
        test_modulo_corners();
        test_arith_logic();
        test_moves_and_unknown();
        test_random_stream(350, 0, 0);
        test_random_stream(350, 63, 0);
        test_random_stream(350, 0, 63);
        test_random_stream(350, 37, 37);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/rfae_pkg.sv
sv/rfae_ram.sv
sv/rfae_alu.sv
sv/register_file_alu_executor.sv
test/tb_top.sv
